/* rtl/core/rtt_pkg.sv */
// shared types and constants of the retransmit timeout table
package rtt_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_BITS    = 64;
  localparam int HANDLE_BITS = 32;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int OP_W    = 2;
  localparam int KIND_W  = 2;
  localparam int OKEY_W  = 64;
  localparam int OHAND_W = 32;
  localparam int DROP_W  = 8;
  localparam int TIME_W  = 32;
  localparam int RCNT_W  = 5;
  localparam int CIDX_W  = 1;
  localparam int CDATA_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET   = TIME_W'(1000);
  localparam logic [DROP_W-1:0] MAX_DROPS_RESET = DROP_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_ACK    = 2'd1,
    KIND_RESEND = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_TIMEOUT   = 1'd0,
    REG_MAX_DROPS = 1'd1
  } reg_idx_t;

  typedef struct packed {
    op_t                    op;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [DROP_W-1:0]      drops;
    logic [TIME_W-1:0]      now;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] timeout;
    logic [DROP_W-1:0] max_drops;
  } cfg_t;

endpackage

/* rtl/core/retransmit_timeout_table_unit.sv */
// top level of the retransmit timeout table: config registers, front and back
//
// Holds up to 16 outstanding messages awaiting acknowledgement.
// Input channel (in_*): opcode 0 pushes a key, payload handle, drop count and
// time; 1 acknowledges a key; 2 runs a timeout tick at in_now_ms; 3 is dropped.
// Result channel (out_*): one reply per push or ack; a tick gives one resend
// item per resent entry, then a tick done item with out_last set.
// Config channel (cfg_*): index 0 timeout_ms, index 1 max_drops, always ready;
// write only while no item is in flight.
// Items pass through a two-deep command queue into a scan engine that visits
// one table slot per cycle unless a result waits on a held output register.
// Each item is first loaded into the engine; a push or ack then visits 1 to 16
// slots (stopping at the first free or matching slot), a tick all 16 slots and
// then places the tick done item.
// A stalled receiver holds the single output register; the engine waits only
// when it has a result to place, and the queue keeps accepting until full.
// Reset (rst_n low, synchronous) empties the table and the queue, clears the
// slot pointer and loads timeout_ms 1000 and max_drops 3.
module retransmit_timeout_table_unit
  import rtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [63:0]         in_msg_key,
  input  logic [31:0]         in_payload_handle,
  input  logic [DROP_W-1:0]   in_initial_drops,
  input  logic [TIME_W-1:0]   in_now_ms,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic                out_ok,
  output logic [OKEY_W-1:0]   out_key,
  output logic [OHAND_W-1:0]  out_payload,
  output logic [DROP_W-1:0]   out_drops,
  output logic [RCNT_W-1:0]   out_resend_count,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CDATA_W-1:0]  cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_TIMEOUT:   cfg_nxt.timeout   = TIME_W'(cfg_data);
        REG_MAX_DROPS: cfg_nxt.max_drops = DROP_W'(cfg_data);
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout   <= TIMEOUT_RESET;
      cfg_r.max_drops <= MAX_DROPS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rtt_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_msg_key        (in_msg_key),
    .in_payload_handle (in_payload_handle),
    .in_initial_drops  (in_initial_drops),
    .in_now_ms         (in_now_ms),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd)
  );

  rtt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_ok           (out_ok),
    .out_key          (out_key),
    .out_payload      (out_payload),
    .out_drops        (out_drops),
    .out_resend_count (out_resend_count),
    .out_last         (out_last)
  );

  // resend items are never final and always ok
  a_resend_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_RESEND) |-> out_ok && !out_last)
    else $error("resend item with bad ok or last");

  // only tick done carries a resend count
  a_count_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_TICK) |-> (out_resend_count == '0))
    else $error("resend count outside tick done");

  // replies and tick done close their item
  a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_RESEND) |-> out_last)
    else $error("final result without last");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

/* rtl/core/rtt_front.sv */
// input decode and command queue of the retransmit timeout table
module rtt_front
  import rtt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [63:0]           in_msg_key,
  input  logic [31:0]           in_payload_handle,
  input  logic [DROP_W-1:0]     in_initial_drops,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output cmd_t                  cmd
);

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept, push, pop;
  op_t               op_dec;
  cmd_t              cmd_in;

  assign in_ready  = (cnt_r != QCNT_W'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem[rd_ptr_r];

  assign accept = in_valid && in_ready;
  assign op_dec = op_t'(in_opcode);
  // opcode three causes nothing and never enters the queue
  assign push   = accept && (op_dec != OP_NONE);
  assign pop    = cmd_valid && cmd_ready;

  always_comb begin
    cmd_in.op     = op_dec;
    cmd_in.key    = KEY_BITS'(in_msg_key);
    cmd_in.handle = HANDLE_BITS'(in_payload_handle);
    cmd_in.drops  = in_initial_drops;
    cmd_in.now    = in_now_ms;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

/* rtl/core/rtt_back.sv */
// table storage and scan engine of the retransmit timeout table
module rtt_back
  import rtt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  input  cfg_t                cfg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic                out_ok,
  output logic [OKEY_W-1:0]   out_key,
  output logic [OHAND_W-1:0]  out_payload,
  output logic [DROP_W-1:0]   out_drops,
  output logic [RCNT_W-1:0]   out_resend_count,
  output logic                out_last
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [ENTRIES-1:0]     valid_r, valid_nxt;
  logic [KEY_BITS-1:0]    key_mem    [ENTRIES];
  logic [HANDLE_BITS-1:0] handle_mem [ENTRIES];
  logic [TIME_W-1:0]      stamp_mem  [ENTRIES];
  logic [DROP_W-1:0]      drops_mem  [ENTRIES];

  logic [KEY_BITS-1:0]    rd_key_r;
  logic [HANDLE_BITS-1:0] rd_handle_r;
  logic [TIME_W-1:0]      rd_stamp_r;
  logic [DROP_W-1:0]      rd_drops_r;

  cmd_t             cmd_r, cmd_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic [OKEY_W-1:0]   out_key_r, out_key_nxt;
  logic [OHAND_W-1:0]  out_payload_r, out_payload_nxt;
  logic [DROP_W-1:0]   out_drops_r, out_drops_nxt;
  logic [RCNT_W-1:0]   out_count_r, out_count_nxt;
  logic                out_last_r, out_last_nxt;

  logic                   e_valid;
  logic [KEY_BITS-1:0]    e_key;
  logic [HANDLE_BITS-1:0] e_handle;
  logic [TIME_W-1:0]      e_stamp;
  logic [DROP_W-1:0]      e_drops;
  logic [TIME_W-1:0]      age;
  logic [DROP_W-1:0]      drops_inc;
  logic [IDX_W-1:0]       slot_inc;
  logic                   last_step, expired, can_emit;
  logic                   emit, step;
  logic                   wr_push, wr_resend;

  assign e_valid   = valid_r[slot_r];
  assign e_key     = rd_key_r;
  assign e_handle  = rd_handle_r;
  assign e_stamp   = rd_stamp_r;
  assign e_drops   = rd_drops_r;
  assign age       = cmd_r.now - e_stamp;
  assign expired   = (age >= cfg.timeout);
  assign drops_inc = e_drops + 1'b1;
  assign slot_inc  = (slot_r == IDX_W'(ENTRIES - 1)) ? '0 : slot_r + 1'b1;
  assign last_step = (idx_r == IDX_W'(ENTRIES - 1));
  assign can_emit  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    cmd_nxt         = cmd_r;
    ptr_nxt         = ptr_r;
    slot_nxt        = slot_r;
    idx_nxt         = idx_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_ok_nxt      = out_ok_r;
    out_key_nxt     = out_key_r;
    out_payload_nxt = out_payload_r;
    out_drops_nxt   = out_drops_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    emit            = 1'b0;
    step            = 1'b0;
    wr_push         = 1'b0;
    wr_resend       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          slot_nxt  = ptr_r;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        out_kind_nxt    = KIND_PUSH;
        out_ok_nxt      = 1'b0;
        out_key_nxt     = '0;
        out_payload_nxt = '0;
        out_drops_nxt   = '0;
        out_count_nxt   = '0;
        out_last_nxt    = 1'b1;
        case (cmd_r.op)
          OP_PUSH: begin
            out_kind_nxt = KIND_PUSH;
            if (!e_valid) begin
              emit       = 1'b1;
              out_ok_nxt = 1'b1;
            end else if (last_step) begin
              emit = 1'b1;
            end
          end
          OP_ACK: begin
            out_kind_nxt = KIND_ACK;
            if (e_valid && (e_key == cmd_r.key)) begin
              emit       = 1'b1;
              out_ok_nxt = 1'b1;
            end else if (last_step) begin
              emit = 1'b1;
            end
          end
          OP_TICK: begin
            if (e_valid && expired && (e_drops < cfg.max_drops)) begin
              emit            = 1'b1;
              out_kind_nxt    = KIND_RESEND;
              out_ok_nxt      = 1'b1;
              out_key_nxt     = OKEY_W'(e_key);
              out_payload_nxt = OHAND_W'(e_handle);
              out_drops_nxt   = drops_inc;
              out_last_nxt    = 1'b0;
            end
          end
          default: begin
          end
        endcase

        step = !emit || can_emit;
        if (step) begin
          if (emit) begin
            out_valid_nxt = 1'b1;
          end
          slot_nxt = slot_inc;
          idx_nxt  = idx_r + 1'b1;
          case (cmd_r.op)
            OP_PUSH: begin
              if (!e_valid) begin
                wr_push            = 1'b1;
                valid_nxt[slot_r]  = 1'b1;
                ptr_nxt            = slot_r;
                state_nxt          = ST_IDLE;
              end else if (last_step) begin
                state_nxt = ST_IDLE;
              end
            end
            OP_ACK: begin
              if (e_valid && (e_key == cmd_r.key)) begin
                valid_nxt[slot_r] = 1'b0;
                state_nxt         = ST_IDLE;
              end else if (last_step) begin
                state_nxt = ST_IDLE;
              end
            end
            OP_TICK: begin
              if (e_valid && expired) begin
                if (e_drops < cfg.max_drops) begin
                  wr_resend = 1'b1;
                  cnt_nxt   = cnt_r + 1'b1;
                end else begin
                  valid_nxt[slot_r] = 1'b0;
                end
              end
              if (last_step) begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end

        // the output data fields only change when a new item is placed
        if (!(emit && step)) begin
          out_kind_nxt    = out_kind_r;
          out_ok_nxt      = out_ok_r;
          out_key_nxt     = out_key_r;
          out_payload_nxt = out_payload_r;
          out_drops_nxt   = out_drops_r;
          out_count_nxt   = out_count_r;
          out_last_nxt    = out_last_r;
        end
      end

      ST_DONE: begin
        if (can_emit) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = KIND_TICK;
          out_ok_nxt      = 1'b1;
          out_key_nxt     = '0;
          out_payload_nxt = '0;
          out_drops_nxt   = '0;
          out_count_nxt   = RCNT_W'(cnt_r);
          out_last_nxt    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    slot_r        <= slot_nxt;
    idx_r         <= idx_nxt;
    cnt_r         <= cnt_nxt;
    out_kind_r    <= out_kind_nxt;
    out_ok_r      <= out_ok_nxt;
    out_key_r     <= out_key_nxt;
    out_payload_r <= out_payload_nxt;
    out_drops_r   <= out_drops_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_push) begin
      key_mem[slot_r]    <= cmd_r.key;
      handle_mem[slot_r] <= cmd_r.handle;
      stamp_mem[slot_r]  <= cmd_r.now;
      drops_mem[slot_r]  <= cmd_r.drops;
    end else if (wr_resend) begin
      stamp_mem[slot_r]  <= cmd_r.now;
      drops_mem[slot_r]  <= drops_inc;
    end
  end

  // entry of the slot visited next, ready in the cycle that visits it
  always_ff @(posedge clk) begin
    rd_key_r    <= key_mem[slot_nxt];
    rd_handle_r <= handle_mem[slot_nxt];
    rd_stamp_r  <= stamp_mem[slot_nxt];
    rd_drops_r  <= drops_mem[slot_nxt];
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_ok           = out_ok_r;
  assign out_key          = out_key_r;
  assign out_payload      = out_payload_r;
  assign out_drops        = out_drops_r;
  assign out_resend_count = out_count_r;
  assign out_last         = out_last_r;

endmodule
